@@ hw/rtl/ggm_pkg.sv @@
// ggm_pkg: shared types, constants and register codes of the gray gradient magnitude block
// no dependencies; imported by every module under hw/rtl
`timescale 1ns / 1ps

package ggm_pkg;

	// default line length limit of the line store
	localparam int GGM_MAX_COLS = 1024;

	// field widths
	localparam int PIX_W      = 8;
	localparam int MAG_W      = 8;
	localparam int ROW_W      = 16;
	localparam int OUT_COL_W  = 10;
	localparam int CFG_COLS_W = 11;
	localparam int CFG_ROWS_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// one line store word holds the older row gray over the recent row gray
	localparam int WORD_W = 2 * PIX_W;

	// reset values of the configuration registers
	localparam logic [CFG_COLS_W-1:0] IMAGE_COLS_RST = CFG_COLS_W'(640);
	localparam logic [CFG_ROWS_W-1:0] IMAGE_ROWS_RST = CFG_ROWS_W'(480);

	// gray = (30r + 59g + 11b) div 100, division done as multiply by 2^19/100 rounded up
	localparam int SUM_W      = 15;
	localparam int PROD_W     = 28;
	localparam int GRAY_RECIP = 5243;
	localparam int GRAY_SHIFT = 19;
	localparam int W_RED      = 30;
	localparam int W_GREEN    = 59;
	localparam int W_BLUE     = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_COLS = 2'd0,
		CFG_IMAGE_ROWS = 2'd1
	} cfg_idx_t;

	// one result transaction
	typedef struct packed {
		logic [MAG_W-1:0]     magnitude;
		logic [ROW_W-1:0]     out_row;
		logic [OUT_COL_W-1:0] out_col;
		logic                 run_last;
	} res_t;

	// push request from the compute stage into the result buffer
	typedef struct packed {
		logic push;
		logic two;
	} push_t;

endpackage

@@ hw/rtl/ggm_lstore.sv @@
// ggm_lstore: two-row gray line store, one write port and two registered read ports
// with write-to-read bypass; depends on ggm_pkg
`timescale 1ns / 1ps

module ggm_lstore #(
	parameter int DEPTH = ggm_pkg::GGM_MAX_COLS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [ggm_pkg::WORD_W-1:0]  wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr_a,
	input  logic [AW-1:0]               raddr_b,
	output logic [ggm_pkg::WORD_W-1:0]  rdata_a,
	output logic [ggm_pkg::WORD_W-1:0]  rdata_b
);
	import ggm_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rd_a_q;
	logic [WORD_W-1:0] rd_b_q;
	logic [WORD_W-1:0] byp_data_q;
	logic              byp_a_q;
	logic              byp_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q     <= mem_q[raddr_a];
			rd_b_q     <= mem_q[raddr_b];
			byp_data_q <= wdata;
		end
	end

	// a write in the same cycle as a read of that address wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_a_q <= 1'b0;
			byp_b_q <= 1'b0;
		end else if (re) begin
			byp_a_q <= we && (waddr == raddr_a);
			byp_b_q <= we && (waddr == raddr_b);
		end
	end

	assign rdata_a = byp_a_q ? byp_data_q : rd_a_q;
	assign rdata_b = byp_b_q ? byp_data_q : rd_b_q;

endmodule

@@ hw/rtl/ggm_rbuf.sv @@
// ggm_rbuf: two-entry result buffer in front of the output channel
// depends on ggm_pkg (res_t, push_t)
`timescale 1ns / 1ps

module ggm_rbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  ggm_pkg::push_t push_req,
	input  ggm_pkg::res_t  res0,
	input  ggm_pkg::res_t  res1,
	output logic           free,
	output logic           out_valid,
	input  logic           out_ready,
	output ggm_pkg::res_t  out_res
);
	import ggm_pkg::*;

	logic a_valid_q;
	logic b_valid_q;
	res_t a_q;
	res_t b_q;
	logic pop;

	assign pop  = a_valid_q && out_ready;
	// both entries empty after this edge
	assign free = !b_valid_q && (!a_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else if (push_req.push) begin
			a_valid_q <= 1'b1;
			b_valid_q <= push_req.two;
		end else if (pop) begin
			a_valid_q <= b_valid_q;
			b_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_req.push) begin
			a_q <= res0;
			b_q <= res1;
		end else if (pop && b_valid_q) begin
			a_q <= b_q;
		end
	end

	assign out_valid = a_valid_q;
	assign out_res   = a_q;

endmodule

@@ hw/rtl/gray_gradient_magnitude_top.sv @@
// gray_gradient_magnitude_top: rgb to gray, two-row line store, central-difference magnitude
// depends on ggm_pkg, ggm_lstore, ggm_rbuf
// path: an accepted pixel is registered in the compute stage, its results in the result buffer that feeds the output
// throughput: one pixel per clock while the result buffer drains; a last-row pixel below another row gives two
// results and holds back the next pixel, since the output port moves one result per clock
// reset: async active low; clears counters, valids, left neighbor; 640 x 480; no store clear
`timescale 1ns / 1ps

module gray_gradient_magnitude_top #(
	parameter int MAX_COLS = ggm_pkg::GGM_MAX_COLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [ggm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ggm_pkg::CFG_DATA_W-1:0]   cfg_data,
	// pixel input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ggm_pkg::PIX_W-1:0]        red,
	input  logic [ggm_pkg::PIX_W-1:0]        green,
	input  logic [ggm_pkg::PIX_W-1:0]        blue,
	// result output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ggm_pkg::MAG_W-1:0]        magnitude,
	output logic [ggm_pkg::ROW_W-1:0]        out_row,
	output logic [ggm_pkg::OUT_COL_W-1:0]    out_col,
	output logic                             run_last
);
	import ggm_pkg::*;

	localparam int CW   = $clog2(MAX_COLS);        // column index width
	localparam int CNTW = $clog2(MAX_COLS + 1);    // holds MAX_COLS itself
	localparam int EW   = (CNTW > CFG_COLS_W) ? CNTW : CFG_COLS_W;

	// absolute difference halved, truncating
	function automatic logic [PIX_W-1:0] half_abs(input logic [PIX_W-1:0] a,
	                                              input logic [PIX_W-1:0] b);
		logic [PIX_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return d >> 1;
	endfunction

	// configuration registers
	logic [CFG_COLS_W-1:0] image_cols_q;
	logic [CFG_ROWS_W-1:0] image_rows_q;

	// position of the next pixel
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;

	// effective frame size
	logic [EW-1:0]    cols_ext;
	logic [CNTW-1:0]  eff_cols;
	logic [CW-1:0]    cols_m1;
	logic [ROW_W-1:0] rows_m1;
	logic [CW-1:0]    cur_j;
	logic [ROW_W-1:0] cur_i;
	logic [CW-1:0]    right_addr;
	logic             cur_last_row;
	logic             cur_interior;

	// handshake
	logic accept;
	logic adv;
	logic n_zero;

	// compute stage
	logic             valid_s1;
	logic [PIX_W-1:0] red_s1;
	logic [PIX_W-1:0] green_s1;
	logic [PIX_W-1:0] blue_s1;
	logic [ROW_W-1:0] row_s1;
	logic [CW-1:0]    col_s1;
	logic             has_up_s1;
	logic             last_row_s1;
	logic             interior_s1;

	logic [PIX_W-1:0] left_q;     // gray at (i-1, j-1)

	logic [SUM_W-1:0]  wsum;
	logic [PROD_W-1:0] gray_prod;
	logic [PIX_W-1:0]  gray;
	logic [WORD_W-1:0] rd_a;
	logic [WORD_W-1:0] rd_b;
	logic [PIX_W-1:0]  up_g;
	logic [PIX_W-1:0]  mid_g;
	logic [PIX_W-1:0]  right_g;
	logic [MAG_W-1:0]  mag;

	push_t push_req;
	res_t  row_res;
	res_t  zero_res;
	res_t  res0;
	res_t  out_res;
	logic  buf_free;

	// effective columns: zero acts as one, above the store depth acts as the depth
	always_comb begin
		cols_ext = EW'(image_cols_q);
		if (cols_ext == '0) begin
			eff_cols = CNTW'(1);
		end else if (cols_ext > EW'(MAX_COLS)) begin
			eff_cols = CNTW'(MAX_COLS);
		end else begin
			eff_cols = CNTW'(cols_ext);
		end
		cols_m1 = CW'(eff_cols - CNTW'(1));
		rows_m1 = (image_rows_q == '0) ? '0 : image_rows_q - ROW_W'(1);
	end

	// clamped position of the pixel on the input side and its border flags
	always_comb begin
		cur_j        = (col_q > cols_m1) ? cols_m1 : col_q;
		cur_i        = (row_q > rows_m1) ? rows_m1 : row_q;
		cur_last_row = (cur_i == rows_m1);
		// interior of the row above: not first or last row, not first or last column
		cur_interior = (cur_i >= ROW_W'(2)) && (cur_j != '0) && (cur_j < cols_m1);
		right_addr   = (cur_j == CW'(MAX_COLS - 1)) ? '0 : cur_j + CW'(1);
	end

	// a first-row pixel off the last row gives no result and never waits on the output
	assign n_zero   = !has_up_s1 && !last_row_s1;
	assign adv      = valid_s1 && (n_zero || buf_free);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	// configuration and position counters; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_cols_q <= IMAGE_COLS_RST;
			image_rows_q <= IMAGE_ROWS_RST;
			row_q        <= '0;
			col_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_COLS: begin
					image_cols_q <= cfg_data[CFG_COLS_W-1:0];
					row_q        <= '0;
					col_q        <= '0;
				end
				CFG_IMAGE_ROWS: begin
					image_rows_q <= cfg_data[CFG_ROWS_W-1:0];
					row_q        <= '0;
					col_q        <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (cur_j == cols_m1) begin
				col_q <= '0;
				row_q <= cur_last_row ? '0 : cur_i + ROW_W'(1);
			end else begin
				col_q <= cur_j + CW'(1);
				row_q <= cur_i;
			end
		end
	end

	// input register of the compute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1      <= red;
			green_s1    <= green;
			blue_s1     <= blue;
			row_s1      <= cur_i;
			col_s1      <= cur_j;
			has_up_s1   <= (cur_i != '0);
			last_row_s1 <= cur_last_row;
			interior_s1 <= cur_interior;
		end
	end

	// left neighbor of the row above follows the pixel that leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (adv) begin
			left_q <= mid_g;
		end
	end

	// line store: word is {older row, recent row}, read at accept, written when the stage leaves
	ggm_lstore #(
		.DEPTH (MAX_COLS)
	) u_lstore (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (adv),
		.waddr   (col_s1),
		.wdata   ({mid_g, gray}),
		.re      (accept),
		.raddr_a (cur_j),
		.raddr_b (right_addr),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// gray level, exact truncating divide by 100 through the reciprocal
	always_comb begin
		wsum = SUM_W'(red_s1) * SUM_W'(W_RED)
		     + SUM_W'(green_s1) * SUM_W'(W_GREEN)
		     + SUM_W'(blue_s1) * SUM_W'(W_BLUE);
		gray_prod = PROD_W'(wsum) * PROD_W'(GRAY_RECIP);
		gray      = gray_prod[GRAY_SHIFT +: PIX_W];
	end

	assign up_g    = rd_a[WORD_W-1:PIX_W];
	assign mid_g   = rd_a[PIX_W-1:0];
	assign right_g = rd_b[PIX_W-1:0];

	// horizontal plus vertical half difference, zero on the border
	assign mag = interior_s1 ? MAG_W'(half_abs(right_g, left_q)) + MAG_W'(half_abs(gray, up_g))
	                         : '0;

	always_comb begin
		row_res.magnitude = mag;
		row_res.out_row   = row_s1 - ROW_W'(1);
		row_res.out_col   = OUT_COL_W'(col_s1);
		row_res.run_last  = !last_row_s1;

		zero_res.magnitude = '0;
		zero_res.out_row   = row_s1;
		zero_res.out_col   = OUT_COL_W'(col_s1);
		zero_res.run_last  = 1'b1;

		res0 = has_up_s1 ? row_res : zero_res;

		push_req.push = adv && !n_zero;
		push_req.two  = has_up_s1 && last_row_s1;
	end

	ggm_rbuf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_req  (push_req),
		.res0      (res0),
		.res1      (zero_res),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign magnitude = out_res.magnitude;
	assign out_row   = out_res.out_row;
	assign out_col   = out_res.out_col;
	assign run_last  = out_res.run_last;

endmodule

@@ hw/rtl/ggm_checker.sv @@
// ggm_checker: port-level checks of the gray gradient magnitude block, bound to the top level
// depends on ggm_pkg and gray_gradient_magnitude_top
`timescale 1ns / 1ps

module ggm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ggm_pkg::MAG_W-1:0]     magnitude,
	input logic [ggm_pkg::ROW_W-1:0]     out_row,
	input logic [ggm_pkg::OUT_COL_W-1:0] out_col,
	input logic                          run_last
);
	import ggm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(out_row)
		&& $stable(out_col) && $stable(run_last))
		else $error("result changed while stalled");

	// magnitude never exceeds the sum of two halved byte differences
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> magnitude <= MAG_W'(254))
		else $error("magnitude out of range");

	// a result that is not the last of its pixel is followed at once by the next one
	a_pair_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("second result of a pixel missing");

	// that second result is the zero border pixel one row further down, same column
	a_pair_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> magnitude == '0 && run_last
		&& out_col == $past(out_col) && out_row == $past(out_row) + ROW_W'(1))
		else $error("second result of a pixel has wrong contents");

endmodule

bind gray_gradient_magnitude_top ggm_checker u_ggm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.magnitude (magnitude),
	.out_row   (out_row),
	.out_col   (out_col),
	.run_last  (run_last)
);
